@@ rtl/gsbb_pkg.sv @@
package gsbb_pkg;

	localparam int unsigned TAG_W   = 20;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned SCALE_W = 31;
	localparam int unsigned CODE_W  = 8;

	// rotation matrix entries are integers over 2^14, magnitude at most 2^16
	localparam int unsigned M_FRAC = 14;
	localparam int unsigned M_W    = 19;
	localparam int unsigned MABS_W = 17;
	localparam logic signed [M_W-1:0] M_ONE = 19'sd16384;

	typedef struct packed {
		logic [TAG_W-1:0]          splat_index;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [POS_W-1:0]   pos_z;
		logic [SCALE_W-1:0]        scale_x;
		logic [SCALE_W-1:0]        scale_y;
		logic [SCALE_W-1:0]        scale_z;
		logic [CODE_W-1:0]         rot_x_code;
		logic [CODE_W-1:0]         rot_y_code;
		logic [CODE_W-1:0]         rot_z_code;
		logic [CODE_W-1:0]         rot_w_code;
	} gsbb_in_t;

	typedef struct packed {
		logic [TAG_W-1:0]          tag_out;
		logic signed [POS_W-1:0]   box_min_x;
		logic signed [POS_W-1:0]   box_max_x;
		logic signed [POS_W-1:0]   box_min_y;
		logic signed [POS_W-1:0]   box_max_y;
		logic signed [POS_W-1:0]   box_min_z;
		logic signed [POS_W-1:0]   box_max_z;
		logic                      clipped;
	} gsbb_out_t;

endpackage

@@ rtl/gaussian_splat_bounding_box_top.sv @@
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+------------------------------
// input    | splat_valid | splat_ready | splat (gsbb_in_t), one splat
// output   | box_valid   | box_ready   | box (gsbb_out_t), one box
//
// six register stages: quaternion products, matrix entries times span,
// scale multiplies, three-way max, bound sums, round and saturate
// one splat per cycle unless a full pipe is stalled by box_ready low
// arst_n clears the stage valid bits only; no clearing pass
// each stage holds when the one after it is full and stalled, so bubbles
// close up and a stalled box never blocks earlier empty stages
module gaussian_splat_bounding_box_top #(
	parameter int unsigned SIGMA_SPAN = 3,
	parameter int unsigned TAG_BITS   = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               splat_valid,
	output logic               splat_ready,
	input  gsbb_pkg::gsbb_in_t splat,
	output logic               box_valid,
	input  logic               box_ready,
	output gsbb_pkg::gsbb_out_t box
);
	import gsbb_pkg::*;

	localparam int unsigned TAG_KEEP = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int unsigned AM_W     = $clog2(65536 * SIGMA_SPAN + 1);
	localparam int unsigned E_W      = SCALE_W + AM_W;
	localparam int unsigned B_W      = E_W + 2;
	localparam int unsigned Q_W      = B_W - M_FRAC;

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || box_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign splat_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= splat_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// tag and position travel alongside
	logic [TAG_KEEP-1:0] tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic signed [POS_W-1:0] pos_s1 [3];
	logic signed [POS_W-1:0] pos_s2 [3];
	logic signed [POS_W-1:0] pos_s3 [3];
	logic signed [POS_W-1:0] pos_s4 [3];
	logic [SCALE_W-1:0] scl_s1 [3];
	logic [SCALE_W-1:0] scl_s2 [3];

	// stage 1: decoded quaternion products, code-128 is the byte with msb flipped
	logic signed [7:0] qx, qy, qz, qw;
	logic signed [15:0] p_xx_s1, p_yy_s1, p_zz_s1, p_xy_s1, p_zw_s1;
	logic signed [15:0] p_xz_s1, p_yw_s1, p_yz_s1, p_xw_s1;

	assign qx = signed'({~splat.rot_x_code[7], splat.rot_x_code[6:0]});
	assign qy = signed'({~splat.rot_y_code[7], splat.rot_y_code[6:0]});
	assign qz = signed'({~splat.rot_z_code[7], splat.rot_z_code[6:0]});
	assign qw = signed'({~splat.rot_w_code[7], splat.rot_w_code[6:0]});

	always_ff @(posedge clk) begin
		if (en1 && splat_valid) begin
			tag_s1    <= splat.splat_index[TAG_KEEP-1:0];
			pos_s1[0] <= splat.pos_x;
			pos_s1[1] <= splat.pos_y;
			pos_s1[2] <= splat.pos_z;
			scl_s1[0] <= splat.scale_x;
			scl_s1[1] <= splat.scale_y;
			scl_s1[2] <= splat.scale_z;
			p_xx_s1   <= 16'(qx * qx);
			p_yy_s1   <= 16'(qy * qy);
			p_zz_s1   <= 16'(qz * qz);
			p_xy_s1   <= 16'(qx * qy);
			p_zw_s1   <= 16'(qz * qw);
			p_xz_s1   <= 16'(qx * qz);
			p_yw_s1   <= 16'(qy * qw);
			p_yz_s1   <= 16'(qy * qz);
			p_xw_s1   <= 16'(qx * qw);
		end
	end

	// stage 2: matrix entries, magnitude, times span
	logic signed [M_W-1:0] m_c [9];
	logic [MABS_W-1:0] mabs_c [9];
	logic [AM_W-1:0] am_s2 [9];

	always_comb begin
		m_c[0] = M_ONE - ((M_W'(p_yy_s1) + M_W'(p_zz_s1)) <<< 1);
		m_c[1] = (M_W'(p_xy_s1) - M_W'(p_zw_s1)) <<< 1;
		m_c[2] = (M_W'(p_xz_s1) + M_W'(p_yw_s1)) <<< 1;
		m_c[3] = (M_W'(p_xy_s1) + M_W'(p_zw_s1)) <<< 1;
		m_c[4] = M_ONE - ((M_W'(p_xx_s1) + M_W'(p_zz_s1)) <<< 1);
		m_c[5] = (M_W'(p_yz_s1) - M_W'(p_xw_s1)) <<< 1;
		m_c[6] = (M_W'(p_xz_s1) - M_W'(p_yw_s1)) <<< 1;
		m_c[7] = (M_W'(p_yz_s1) + M_W'(p_xw_s1)) <<< 1;
		m_c[8] = M_ONE - ((M_W'(p_xx_s1) + M_W'(p_yy_s1)) <<< 1);
		for (int j = 0; j < 9; j++) begin
			mabs_c[j] = m_c[j][M_W-1] ? MABS_W'(-m_c[j]) : MABS_W'(m_c[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			tag_s2 <= tag_s1;
			for (int j = 0; j < 3; j++) begin
				pos_s2[j] <= pos_s1[j];
				scl_s2[j] <= scl_s1[j];
			end
			for (int j = 0; j < 9; j++) begin
				am_s2[j] <= AM_W'(mabs_c[j]) * AM_W'(SIGMA_SPAN);
			end
		end
	end

	// stage 3: scaled half axis components, entry (i,k) uses scale k
	logic [E_W-1:0] e_s3 [9];

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			tag_s3 <= tag_s2;
			for (int j = 0; j < 3; j++) begin
				pos_s3[j] <= pos_s2[j];
			end
			for (int j = 0; j < 9; j++) begin
				e_s3[j] <= E_W'(scl_s2[j % 3]) * E_W'(am_s2[j]);
			end
		end
	end

	// stage 4: half extent per axis, pairwise compares in parallel
	logic [E_W-1:0] h_c [3];
	logic [E_W-1:0] h_s4 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (e_s3[3*i] >= e_s3[3*i+1] && e_s3[3*i] >= e_s3[3*i+2]) begin
				h_c[i] = e_s3[3*i];
			end else if (e_s3[3*i+1] >= e_s3[3*i+2]) begin
				h_c[i] = e_s3[3*i+1];
			end else begin
				h_c[i] = e_s3[3*i+2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			tag_s4 <= tag_s3;
			for (int i = 0; i < 3; i++) begin
				pos_s4[i] <= pos_s3[i];
				h_s4[i]   <= h_c[i];
			end
		end
	end

	// stage 5: exact bounds over 2^14, upper one biased for ceiling
	logic signed [B_W-1:0] lo_s5 [3];
	logic signed [B_W-1:0] hi_s5 [3];
	logic signed [B_W-1:0] base_c [3];
	logic signed [B_W-1:0] hx_c [3];
	localparam logic signed [B_W-1:0] CEIL_BIAS = B_W'((1 << M_FRAC) - 1);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			base_c[i] = B_W'(pos_s4[i]) <<< M_FRAC;
			hx_c[i]   = signed'(B_W'(h_s4[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			tag_s5 <= tag_s4;
			for (int i = 0; i < 3; i++) begin
				lo_s5[i] <= base_c[i] - hx_c[i];
				hi_s5[i] <= base_c[i] + hx_c[i] + CEIL_BIAS;
			end
		end
	end

	// stage 6: floor by arithmetic shift, then saturate to 32 bits
	logic signed [Q_W-1:0] qv_c [6];
	logic [5:0] ovf_c;
	logic signed [POS_W-1:0] bnd_c [6];
	gsbb_out_t box_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qv_c[2*i]   = Q_W'(lo_s5[i] >>> M_FRAC);
			qv_c[2*i+1] = Q_W'(hi_s5[i] >>> M_FRAC);
		end
		for (int j = 0; j < 6; j++) begin
			ovf_c[j] = (qv_c[j][Q_W-1:POS_W-1] != '0) && (qv_c[j][Q_W-1:POS_W-1] != '1);
			if (ovf_c[j]) begin
				bnd_c[j] = qv_c[j][Q_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
				                          : {1'b0, {(POS_W-1){1'b1}}};
			end else begin
				bnd_c[j] = qv_c[j][POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			box_s6.tag_out   <= TAG_W'(tag_s5);
			box_s6.box_min_x <= bnd_c[0];
			box_s6.box_max_x <= bnd_c[1];
			box_s6.box_min_y <= bnd_c[2];
			box_s6.box_max_y <= bnd_c[3];
			box_s6.box_min_z <= bnd_c[4];
			box_s6.box_max_z <= bnd_c[5];
			box_s6.clipped   <= |ovf_c;
		end
	end

	assign box_valid = v_s6;
	assign box       = box_s6;

	// half extents are never negative, so every box is well ordered
	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (box.box_min_x <= box.box_max_x) && (box.box_min_y <= box.box_max_y)
			&& (box.box_min_z <= box.box_max_z))
		else $error("box bounds out of order");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		splat_valid && splat_ready |=> v_s1)
		else $error("accepted beat lost at stage one");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> splat_ready)
		else $error("input stalled with empty first stage");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && v_s6 && !box_ready |=> v_s5 && v_s6)
		else $error("stalled beat dropped in the tail stages");

endmodule
